>>> rtl/core/vector_terminal_coord_encoder_core_assert.svh
// Assertion macros used by the checker of the coordinate encoder.
// Each macro expects clk and arst_n in scope.
`ifndef VECTOR_TERMINAL_COORD_ENCODER_CORE_ASSERT_SVH
`define VECTOR_TERMINAL_COORD_ENCODER_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset
`define VTCE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication
`define VTCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define VTCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/vtce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtce_pkg;

	// Field widths
	localparam int unsigned COORD_W = 16;
	localparam int unsigned SCALE_W = 24;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned SCR_W   = 10;
	localparam int unsigned PART_W  = 5;
	localparam int unsigned BYTE_W  = 7;

	// Terminal bytes and address tags
	localparam logic [BYTE_W-1:0] BYTE_ESC  = 7'h1B;
	localparam logic [BYTE_W-1:0] BYTE_GS   = 7'h1D;
	localparam logic [1:0]        TAG_HIGH  = 2'b01;
	localparam logic [1:0]        TAG_LOW_X = 2'b10;
	localparam logic [1:0]        TAG_LOW_Y = 2'b11;

	// Reset scale factor: 1.0
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h01_0000;

	// Byte-present mask, in emission order
	localparam int unsigned MB_ESC = 0;
	localparam int unsigned MB_GS  = 1;
	localparam int unsigned MB_HY  = 2;
	localparam int unsigned MB_LY  = 3;
	localparam int unsigned MB_HX  = 4;
	localparam int unsigned MB_LX  = 5;
	localparam int unsigned MASK_W = 6;

	// Command queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SCALE    = 2'd0,
		REG_SIDEWAYS = 2'd1,
		REG_ESCAPE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_factor;
		logic               sideways;
		logic               escape_all;
	} cfg_t;

	// One classified command: which bytes to send plus the address parts
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [PART_W-1:0] hy;
		logic [PART_W-1:0] ly;
		logic [PART_W-1:0] hx;
		logic [PART_W-1:0] lx;
	} entry_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/vector_terminal_coord_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns move/draw commands into vector-terminal address bytes. Each command's
// coordinates are scaled by a UQ8.16 factor, optionally turned a quarter turn,
// and sent as up to six bytes (ESC, GS, high-Y, low-Y, high-X, low-X), one
// beat per cycle on the master side while m_tready is high, with tlast on the
// low-X byte. A command is taken every cycle while the four-entry command
// queue has room; a command of n bytes occupies the output for n beats, so the
// sustained rate is set by the byte serializer. A move to the last point sent
// (the origin after reset) produces no beats. Registers are to be written over
// the cfg port only while the block is idle; the block itself does not enforce it.
module vector_terminal_coord_encoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	// command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [15:0] x_coord, [31:16] y_coord
	input  wire logic        s_tuser,  // [0] mode
	// byte stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [6:0] out_byte, [7] zero
	output logic             m_tlast   // last
);

	vtce_pkg::cfg_t    cfg_q;
	vtce_pkg::q_stat_t q_stat;
	vtce_pkg::entry_t  push_entry, head;
	logic              push, pop;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_factor <= vtce_pkg::SCALE_RESET;
			cfg_q.sideways     <= 1'b0;
			cfg_q.escape_all   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vtce_pkg::REG_SCALE:    cfg_q.scale_factor <= cfg_data;
				vtce_pkg::REG_SIDEWAYS: cfg_q.sideways     <= cfg_data[0];
				vtce_pkg::REG_ESCAPE:   cfg_q.escape_all   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vtce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	vtce_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	vtce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

>>> rtl/core/vtce_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front: input register, scaling multipliers, change classification.
module vtce_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire vtce_pkg::cfg_t                cfg,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [2*vtce_pkg::COORD_W-1:0] s_tdata,
	input  wire logic                          s_tuser,
	input  wire vtce_pkg::q_stat_t             q_stat,
	output logic                               push,
	output vtce_pkg::entry_t                   push_entry
);

	localparam int unsigned CW   = vtce_pkg::COORD_W;
	localparam int unsigned SW   = vtce_pkg::SCR_W;
	localparam int unsigned PW   = vtce_pkg::PART_W;
	localparam int unsigned PRDW = vtce_pkg::SCALE_W + vtce_pkg::COORD_W;

	// stage 1: accepted command
	logic          v_s1;
	logic          mode_s1;
	logic [CW-1:0] x_s1, y_s1;

	// stage 2: screen coordinates
	logic          v_s2;
	logic          mode_s2;
	logic [CW-1:0] x_s2, y_s2;
	logic [SW-1:0] scx_s2, scy_s2;

	// point history
	logic          hist_ok_q;
	logic [PW-1:0] prev_hy_q, prev_ly_q, prev_hx_q;
	logic [CW-1:0] prev_x_q, prev_y_q;

	logic            ld2, adv2, drop2;
	logic [PRDW-1:0] px, py;
	logic [SW-1:0]   sx, sy;
	logic            hy_ch, hx_ch, ly_em;

	// handshake chain
	assign drop2    = !mode_s2 && (x_s2 == prev_x_q) && (y_s2 == prev_y_q);
	assign adv2     = v_s2 && (drop2 || !q_stat.full);
	assign push     = v_s2 && !drop2 && !q_stat.full;
	assign ld2      = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (ld2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			x_s1    <= s_tdata[CW-1:0];
			y_s1    <= s_tdata[2*CW-1:CW];
		end
	end

	// scale: keep screen bits of (factor * coord) >> 16
	assign px = PRDW'(cfg.scale_factor) * PRDW'(x_s1);
	assign py = PRDW'(cfg.scale_factor) * PRDW'(y_s1);

	// quarter turn: x = 1023 - y, low bits only
	always_comb begin
		if (cfg.sideways) begin
			sx = ~py[vtce_pkg::FRAC_W +: SW];
			sy = px[vtce_pkg::FRAC_W +: SW];
		end else begin
			sx = px[vtce_pkg::FRAC_W +: SW];
			sy = py[vtce_pkg::FRAC_W +: SW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			mode_s2 <= mode_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			scx_s2  <= sx;
			scy_s2  <= sy;
		end
	end

	// classify against the last point sent
	assign hy_ch = !hist_ok_q || (scy_s2[SW-1:PW] != prev_hy_q);
	assign hx_ch = !hist_ok_q || (scx_s2[SW-1:PW] != prev_hx_q);
	assign ly_em = !hist_ok_q || (scy_s2[PW-1:0] != prev_ly_q) || hx_ch;

	always_comb begin
		push_entry                           = '0;
		push_entry.mask[vtce_pkg::MB_ESC]    = !mode_s2 && cfg.escape_all;
		push_entry.mask[vtce_pkg::MB_GS]     = !mode_s2;
		push_entry.mask[vtce_pkg::MB_HY]     = hy_ch;
		push_entry.mask[vtce_pkg::MB_LY]     = ly_em;
		push_entry.mask[vtce_pkg::MB_HX]     = hx_ch;
		push_entry.mask[vtce_pkg::MB_LX]     = 1'b1;
		push_entry.hy                        = scy_s2[SW-1:PW];
		push_entry.ly                        = scy_s2[PW-1:0];
		push_entry.hx                        = scx_s2[SW-1:PW];
		push_entry.lx                        = scx_s2[PW-1:0];
	end

	// history update on every command that sends bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_ok_q <= 1'b0;
			prev_hy_q <= '0;
			prev_ly_q <= '0;
			prev_hx_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else if (push) begin
			hist_ok_q <= 1'b1;
			prev_hy_q <= scy_s2[SW-1:PW];
			prev_ly_q <= scy_s2[PW-1:0];
			prev_hx_q <= scx_s2[SW-1:PW];
			prev_x_q  <= x_s2;
			prev_y_q  <= y_s2;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/vtce_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Short command queue between classification and byte serializer.
module vtce_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire vtce_pkg::entry_t push_entry,
	input  wire logic             pop,
	output vtce_pkg::entry_t      head,
	output vtce_pkg::q_stat_t     q_stat
);

	localparam int unsigned AW = vtce_pkg::Q_AW;

	vtce_pkg::entry_t mem_q [vtce_pkg::Q_DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (AW+1)'(vtce_pkg::Q_DEPTH));
	assign q_stat.valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/vtce_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back: walks the byte mask of one command, one beat per cycle unless m_tready stalls the output.
module vtce_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vtce_pkg::entry_t head,
	input  wire vtce_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	localparam int unsigned MW = vtce_pkg::MASK_W;

	logic                 cur_v_q;
	logic [MW-1:0]        rem_q;
	vtce_pkg::entry_t     cur_q;
	logic                 out_v_q;
	logic [vtce_pkg::BYTE_W-1:0] out_byte_q;
	logic                 out_last_q;

	logic          out_free, emit, done;
	logic [MW-1:0] rem_nx;
	logic [vtce_pkg::BYTE_W-1:0] sel_byte;

	assign out_free = !out_v_q || m_tready;
	assign emit     = cur_v_q && out_free;
	assign rem_nx   = rem_q & (rem_q - 1'b1);
	assign done     = emit && (rem_nx == '0);
	assign pop      = q_stat.valid && (!cur_v_q || done);

	// first pending byte, in send order
	always_comb begin
		if (rem_q[vtce_pkg::MB_ESC]) begin
			sel_byte = vtce_pkg::BYTE_ESC;
		end else if (rem_q[vtce_pkg::MB_GS]) begin
			sel_byte = vtce_pkg::BYTE_GS;
		end else if (rem_q[vtce_pkg::MB_HY]) begin
			sel_byte = {vtce_pkg::TAG_HIGH, cur_q.hy};
		end else if (rem_q[vtce_pkg::MB_LY]) begin
			sel_byte = {vtce_pkg::TAG_LOW_Y, cur_q.ly};
		end else if (rem_q[vtce_pkg::MB_HX]) begin
			sel_byte = {vtce_pkg::TAG_HIGH, cur_q.hx};
		end else begin
			sel_byte = {vtce_pkg::TAG_LOW_X, cur_q.lx};
		end
	end

	// current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			rem_q   <= '0;
		end else if (pop) begin
			cur_v_q <= 1'b1;
			rem_q   <= head.mask;
		end else if (done) begin
			cur_v_q <= 1'b0;
			rem_q   <= '0;
		end else if (emit) begin
			rem_q   <= rem_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= (rem_nx == '0);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/vtce_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "vector_terminal_coord_encoder_core_assert.svh"

// Port-level checks on the byte stream.
module vtce_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	localparam logic [6:0] ESC = 7'h1B;
	localparam logic [6:0] GS  = 7'h1D;

	// stalled beat holds
	`VTCE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")

	// every beat is ESC, GS or an address byte, padding bit clear
	`VTCE_ASSERT_IMPLY(a_code, m_tvalid, !m_tdata[7] && (m_tdata[6:5] != 2'b00 || m_tdata[6:0] == ESC || m_tdata[6:0] == GS), "bad byte code")

	// a command ends exactly on its low-X byte
	`VTCE_ASSERT_IMPLY(a_last, m_tvalid, m_tlast == (m_tdata[6:5] == 2'b10), "tlast not on low-X byte")

	// ESC is sent straight before GS
	`VTCE_ASSERT_NEXT(a_esc_gs, m_tvalid && m_tready && m_tdata[6:0] == ESC, m_tvalid && m_tdata[6:0] == GS, "ESC not followed by GS")

endmodule

bind vector_terminal_coord_encoder_core vtce_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

>>> sim/vector_terminal_coord_encoder_core_test.sv
`timescale 1ns / 1ps

module vector_terminal_coord_encoder_core_test;

	// One terminal byte as it should leave the block
	typedef struct packed {
		logic [vtce_pkg::BYTE_W-1:0] code;
		logic                        tail;
	} term_beat_t;

	// Directed plan: a register write or a command, optionally with bytes typed in
	typedef struct packed {
		logic                         is_reg;
		vtce_pkg::cfg_reg_t           reg_idx;
		logic [vtce_pkg::SCALE_W-1:0] reg_val;
		logic                         md;
		logic [15:0]                  x;
		logic [15:0]                  y;
		int                           n_typed;  // -1: bytes come from the encoder model
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [15:0] x_coord, [31:16] y_coord
	logic        s_tuser;  // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // [6:0] out_byte, [7] zero
	logic        m_tlast;  // last

	// Encoder copy: registers and address history
	logic [vtce_pkg::SCALE_W-1:0] scale_reg;
	logic                         side_reg;
	logic                         esc_reg;
	logic [7:0]                   last_hy, last_ly, last_hx;
	logic [15:0]                  last_x, last_y;

	term_beat_t  addr_byte_q [$];
	logic [6:0]  typed_addr [$];
	plan_row_t   plan [$];
	int          mismatch_cnt = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_len = 0;

	vector_terminal_coord_encoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Encode one command against the current history; returns bytes produced.
	// With emit clear only the history moves (bytes were typed in by hand).
	function automatic int encode_point(input logic md, input logic [15:0] x,
			input logic [15:0] y, input bit emit);
		logic [39:0] px, py;
		logic [31:0] sx, sy;
		logic [7:0]  hx, lx, hy, ly;
		logic        hx_chg;
		logic [6:0]  seq [$];
		term_beat_t  b;
		if (!md && x == last_x && y == last_y) begin
			return 0;
		end
		if (!md) begin
			if (esc_reg)
				seq.push_back(vtce_pkg::BYTE_ESC);
			seq.push_back(vtce_pkg::BYTE_GS);
		end
		px = scale_reg * x;
		py = scale_reg * y;
		// quarter turn: x = 1023 - scaled y (may go negative), y = scaled x
		if (side_reg) begin
			sx = 32'd1023 - {8'd0, py[39:16]};
			sy = {8'd0, px[39:16]};
		end else begin
			sx = {8'd0, px[39:16]};
			sy = {8'd0, py[39:16]};
		end
		hx = {1'b0, vtce_pkg::TAG_HIGH, sx[9:5]};
		lx = {1'b0, vtce_pkg::TAG_LOW_X, sx[4:0]};
		hy = {1'b0, vtce_pkg::TAG_HIGH, sy[9:5]};
		ly = {1'b0, vtce_pkg::TAG_LOW_Y, sy[4:0]};
		hx_chg = (hx != last_hx);
		if (hy != last_hy)
			seq.push_back(hy[6:0]);
		if (ly != last_ly || hx_chg)
			seq.push_back(ly[6:0]);
		if (hx_chg)
			seq.push_back(hx[6:0]);
		seq.push_back(lx[6:0]);
		last_hy = hy;
		last_ly = ly;
		last_hx = hx;
		last_x  = x;
		last_y  = y;
		if (emit) begin
			foreach (seq[k]) begin
				b.code = seq[k];
				b.tail = (k == seq.size() - 1);
				addr_byte_q.push_back(b);
			end
		end
		return seq.size();
	endfunction

	function automatic plan_row_t cmd_row(input logic md, input logic [15:0] x,
			input logic [15:0] y, input int n_typed);
		plan_row_t r;
		r = '0;
		r.md = md;
		r.x = x;
		r.y = y;
		r.n_typed = n_typed;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input vtce_pkg::cfg_reg_t idx,
			input logic [vtce_pkg::SCALE_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Offer one command with random gaps; returns after the accepting edge
	task automatic send_cmd(input logic md, input logic [15:0] x, input logic [15:0] y);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering, wait for every byte, then let the pipe settle
	task automatic drain_bytes;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (addr_byte_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input vtce_pkg::cfg_reg_t idx,
			input logic [vtce_pkg::SCALE_W-1:0] val);
		drain_bytes();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			vtce_pkg::REG_SCALE:    scale_reg = val;
			vtce_pkg::REG_SIDEWAYS: side_reg  = val[0];
			vtce_pkg::REG_ESCAPE:   esc_reg   = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Byte side ready: random stalls, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Byte checker
	always @(posedge clk) begin
		term_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (addr_byte_q.size() == 0) begin
				$error("unexpected beat: out_byte %h last %b", m_tdata[6:0], m_tlast);
				mismatch_cnt++;
			end else begin
				want = addr_byte_q.pop_front();
				if (m_tdata[6:0] !== want.code) begin
					$error("out_byte: expected %h, got %h", want.code, m_tdata[6:0]);
					mismatch_cnt++;
				end
				if (m_tlast !== want.tail) begin
					$error("last: expected %b, got %b", want.tail, m_tlast);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		logic        md;
		logic [15:0] nx, ny;
		int          produced;
		term_beat_t  b;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = vtce_pkg::REG_SCALE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		scale_reg = vtce_pkg::SCALE_RESET;
		side_reg  = 1'b0;
		esc_reg   = 1'b0;
		last_hy   = 8'hFF;
		last_ly   = 8'hFF;
		last_hx   = 8'hFF;
		last_x    = '0;
		last_y    = '0;

		// Directed plan; hand-typed bytes for the easy rows
		plan = '{
			cmd_row(1'b0, 16'd0, 16'd0, 0),          // move to reset point: nothing
			cmd_row(1'b1, 16'd0, 16'd0, 4),
			cmd_row(1'b0, 16'd1023, 16'd1023, 5),
			cmd_row(1'b1, 16'd1023, 16'd1023, 1),    // redraw: low-X only
			cmd_row(1'b0, 16'd1023, 16'd1023, 0),    // move to same point
			cmd_row(1'b1, 16'd1024, 16'd0, 4),       // wraps past 10 bits
			cmd_row(1'b1, 16'hFFFF, 16'hFFFF, 4),
			reg_row(vtce_pkg::REG_ESCAPE, 24'd1),
			cmd_row(1'b0, 16'd0, 16'd0, 6),          // ESC GS plus four address bytes
			cmd_row(1'b1, 16'd0, 16'd32, 2),         // high-Y only changes
			cmd_row(1'b1, 16'd32, 16'd32, 3),        // high-X change forces low-Y
			reg_row(vtce_pkg::REG_SIDEWAYS, 24'd1),
			cmd_row(1'b1, 16'd0, 16'd0, -1),
			cmd_row(1'b1, 16'd0, 16'd2000, -1),      // negative sideways x
			cmd_row(1'b0, 16'd0, 16'd2000, -1),
			cmd_row(1'b0, 16'd5, 16'd2000, -1),
			reg_row(vtce_pkg::REG_SCALE, 24'd0),
			cmd_row(1'b1, 16'hFFFF, 16'hFFFF, -1),
			reg_row(vtce_pkg::REG_SCALE, 24'hFF_FFFF),
			cmd_row(1'b1, 16'hFFFF, 16'hFFFF, -1),
			cmd_row(1'b0, 16'h0001, 16'hAAAA, -1),
			reg_row(vtce_pkg::REG_SIDEWAYS, 24'd0),
			reg_row(vtce_pkg::REG_ESCAPE, 24'd0),
			reg_row(vtce_pkg::REG_SCALE, 24'h00_8000),
			cmd_row(1'b1, 16'd3, 16'd3, -1),
			cmd_row(1'b0, 16'h5555, 16'h5555, -1)
		};
		typed_addr = '{
			7'h20, 7'h60, 7'h20, 7'h40,
			vtce_pkg::BYTE_GS, 7'h3F, 7'h7F, 7'h3F, 7'h5F,
			7'h5F,
			7'h20, 7'h60, 7'h20, 7'h40,
			7'h3F, 7'h7F, 7'h3F, 7'h5F,
			vtce_pkg::BYTE_ESC, vtce_pkg::BYTE_GS, 7'h20, 7'h60, 7'h20, 7'h40,
			7'h21, 7'h40,
			7'h60, 7'h21, 7'h40
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 17;
		snk_idle_pct = 56;
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_cmd(plan[i].md, plan[i].x, plan[i].y);
				produced = encode_point(plan[i].md, plan[i].x, plan[i].y, plan[i].n_typed < 0);
				for (int k = 0; k < plan[i].n_typed; k++) begin
					b.code = typed_addr.pop_front();
					b.tail = (k == plan[i].n_typed - 1);
					addr_byte_q.push_back(b);
				end
			end
		end

		// Random part: three idle mixes, three register settings each
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 56 : 0;
			snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 17 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				case ($urandom_range(4))
					0: write_reg(vtce_pkg::REG_SCALE, vtce_pkg::SCALE_RESET);
					1: write_reg(vtce_pkg::REG_SCALE, 24'd0);
					2: write_reg(vtce_pkg::REG_SCALE, 24'hFF_FFFF);
					3: write_reg(vtce_pkg::REG_SCALE,
						24'($urandom_range(24'h00_4000, 24'h04_0000)));
					default: write_reg(vtce_pkg::REG_SCALE, 24'($urandom));
				endcase
				write_reg(vtce_pkg::REG_SIDEWAYS, 24'($urandom_range(1)));
				write_reg(vtce_pkg::REG_ESCAPE, 24'($urandom_range(1)));
				// long output hold-off so the command queue fills and input stalls
				if (ph == 2 && blk == 0) begin
					hold_len = 300;
					hold_req = 1'b1;
				end
				produced = 0;
				while (produced < 45) begin
					md = 1'($urandom_range(1));
					case ($urandom_range(9))
						0, 1: begin
							nx = last_x;
							ny = last_y;
						end
						2, 3: begin
							nx = last_x ^ (16'd1 << $urandom_range(5));
							ny = last_y ^ (16'd1 << $urandom_range(5));
						end
						4, 5: begin
							nx = 16'($urandom_range(1023));
							ny = 16'($urandom_range(1023));
						end
						default: begin
							nx = 16'($urandom);
							ny = 16'($urandom);
						end
					endcase
					send_cmd(md, nx, ny);
					if (encode_point(md, nx, ny, 1'b1) != 0)
						produced++;
				end
			end
		end

		drain_bytes();
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/vtce_pkg.sv
rtl/core/vtce_front.sv
rtl/core/vtce_fifo.sv
rtl/core/vtce_back.sv
rtl/core/vector_terminal_coord_encoder_core.sv
rtl/core/vtce_chk.sv
sim/vector_terminal_coord_encoder_core_test.sv
